[sv/rlsa_pkg.sv]
// Shared types and constants for the rate-limited step accumulator.
// No dependencies; every other file refers to this package by scoped names.
package rlsa_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DELTA_W    = 16;
  localparam int TIME_W     = 48;
  localparam int FRAME_W    = 4;   // width of the frame index port
  localparam int SUM_W      = 13;  // signed movement accumulator
  localparam int MAG_W      = 12;  // magnitude of the accumulator
  localparam int QUO_W      = 4;   // step count magnitude, at most 15
  localparam int UNIT_W     = 14;  // width of the shared add/subtract unit

  localparam logic [7:0]  STEP_DIV_RST     = 8'd24;
  localparam logic [3:0]  MAX_STEPS_RST    = 4'd3;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_DIV     = 2'd0,
    CFG_MAX_STEPS    = 2'd1,
    CFG_MIN_INTERVAL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  step_divisor;
    logic [3:0]  max_steps;
    logic [15:0] min_interval;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_WRAP,
    ST_DONE
  } state_e;

endpackage

[sv/rlsa_alu.sv]
// Shared add/subtract unit of the step accumulator, used for division steps
// and for the frame wrap. Depends on rlsa_pkg.
module rlsa_alu (
  input  logic signed [rlsa_pkg::UNIT_W-1:0] a_i,
  input  logic signed [rlsa_pkg::UNIT_W-1:0] b_i,
  input  logic                               sub_i,
  output logic signed [rlsa_pkg::UNIT_W-1:0] res_o,
  output logic                               neg_o
);

  assign res_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign neg_o = res_o[rlsa_pkg::UNIT_W-1];

endmodule

[sv/rlsa_cfg.sv]
// Configuration register file of the step accumulator.
// Depends on rlsa_pkg; writes to unknown indexes are dropped.
module rlsa_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [rlsa_pkg::CFG_IDX_W-1:0]      wr_idx_i,
  input  logic [rlsa_pkg::CFG_DATA_W-1:0]     wr_data_i,
  output rlsa_pkg::cfg_t                      cfg_o
);

  rlsa_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        rlsa_pkg::CFG_STEP_DIV:     cfg_d.step_divisor = wr_data_i[7:0];
        rlsa_pkg::CFG_MAX_STEPS:    cfg_d.max_steps    = wr_data_i[3:0];
        rlsa_pkg::CFG_MIN_INTERVAL: cfg_d.min_interval = wr_data_i;
        default:                    cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_divisor <= rlsa_pkg::STEP_DIV_RST;
      cfg_q.max_steps    <= rlsa_pkg::MAX_STEPS_RST;
      cfg_q.min_interval <= rlsa_pkg::MIN_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/rate_limited_step_accumulator.sv]
// Top level of the rate-limited step accumulator: sequencer, state and
// output register. Depends on rlsa_pkg, rlsa_alu and rlsa_cfg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: func_i = 0 is a
//   roll that adds delta_i to the movement accumulator at time now_time_i,
//   func_i = 1 is a settle that clears the accumulator. Every item gives
//   exactly one result on the output channel (out_valid_o/out_ready_i):
//   the frame index after the item and whether the item moved it.
//   The configuration channel (cfg_valid_i/cfg_ready_o) writes register
//   cfg_index_i: 0 step divisor, 1 step bound, 2 minimum frame interval.
//   It is always ready; write it only while the block is idle.
// Timing:
//   The block takes one item at a time; in_ready_o is high only in idle.
//   A settle goes from idle straight to the final state. A roll passes the
//   accumulate state; when the interval has elapsed and the divisor is
//   nonzero it then runs four restoring compare-subtract iterations
//   through the shared add/subtract unit and, if it steps, wraps the frame
//   by one FRAME_COUNT per cycle on the same unit.
//   The result sits in an output register, so a new item is accepted while
//   the receiver stalls; the sequencer then holds in its final state until
//   the output register frees up.
// Reset:
//   Accumulator, frame index and last change time clear to zero; the
//   registers return to divisor 24, bound 3 and interval 60.
module rate_limited_step_accumulator #(
  parameter int FRAME_COUNT = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rlsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rlsa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic signed [rlsa_pkg::DELTA_W-1:0] delta_i,
  input  logic [rlsa_pkg::TIME_W-1:0]         now_time_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rlsa_pkg::FRAME_W-1:0]        frame_index_o,
  output logic                                frame_changed_o
);

  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int UW = rlsa_pkg::UNIT_W;
  localparam int MW = rlsa_pkg::MAG_W;
  localparam int SW = rlsa_pkg::SUM_W;
  localparam int QW = rlsa_pkg::QUO_W;
  localparam int TW = rlsa_pkg::TIME_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  rlsa_pkg::cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  rlsa_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  rlsa_pkg::state_e state_q, state_d;

  logic signed [SW-1:0]   ms_q, ms_d;        // movement accumulator
  logic [FW-1:0]          cur_q, cur_d;      // current frame
  logic [TW-1:0]          last_q, last_d;    // time of last frame change
  logic                   chg_q, chg_d;      // this item changed the frame
  logic                   out_valid_q, out_valid_d;

  // per-item working registers, no reset needed
  logic signed [rlsa_pkg::DELTA_W-1:0] delta_q, delta_d;
  logic [TW-1:0]          now_q, now_d;
  logic                   elapsed_q, elapsed_d;
  logic [MW-1:0]          rem_q, rem_d;      // remainder magnitude
  logic                   neg_q, neg_d;      // accumulator sign
  logic [QW-1:0]          quo_q, quo_d;      // step count magnitude
  logic [1:0]             bit_q, bit_d;      // quotient bit under test
  logic signed [UW-1:0]   f_q, f_d;          // unwrapped frame
  logic [rlsa_pkg::FRAME_W-1:0] out_frame_q, out_frame_d;
  logic                   out_chg_q, out_chg_d;

  // ---------------------------------------------------------------------------
  // Shared add/subtract unit
  // ---------------------------------------------------------------------------
  logic signed [UW-1:0] alu_a, alu_b, alu_res;
  logic                 alu_sub, alu_neg;

  rlsa_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [MW-1:0]        limit_w;
  logic signed [16:0]   lim_s, sum_w, clamp_w, mag_w;
  logic [TW-1:0]        diff_w;
  logic                 elapsed_w;
  logic signed [UW-1:0] div_ext, fc_ext, cur_ext, q_ext;
  logic [QW-1:0]        quo_next;
  logic [MW-1:0]        rem_next;
  logic                 take_w;

  assign limit_w = MW'(cfg.max_steps) * MW'(cfg.step_divisor);
  assign lim_s   = $signed({5'b0, limit_w});
  assign sum_w   = 17'(ms_q) + 17'(delta_q);

  always_comb begin
    if (sum_w > lim_s) begin
      clamp_w = lim_s;
    end else if (sum_w < -lim_s) begin
      clamp_w = -lim_s;
    end else begin
      clamp_w = sum_w;
    end
  end

  assign mag_w = clamp_w[16] ? -clamp_w : clamp_w;

  // signed time since the last change; a negative difference is too early
  assign diff_w    = now_time_i - last_q;
  assign elapsed_w = !diff_w[TW-1] && (diff_w >= TW'(cfg.min_interval));

  assign div_ext = UW'(cfg.step_divisor);
  assign fc_ext  = UW'(FRAME_COUNT);
  assign cur_ext = UW'(cur_q);

  // alu operands: division step in ST_DIV, frame wrap otherwise
  always_comb begin
    if (state_q == rlsa_pkg::ST_DIV) begin
      alu_a   = UW'(rem_q);
      alu_b   = div_ext << bit_q;
      alu_sub = 1'b1;
    end else begin
      alu_a   = f_q;
      alu_b   = fc_ext;
      alu_sub = !f_q[UW-1];
    end
  end

  assign take_w   = !alu_neg;
  assign quo_next = take_w ? (quo_q | (QW'(1) << bit_q)) : quo_q;
  assign rem_next = take_w ? alu_res[MW-1:0] : rem_q;
  assign q_ext    = UW'(quo_next);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    ms_d        = ms_q;
    cur_d       = cur_q;
    last_d      = last_q;
    chg_d       = chg_q;
    delta_d     = delta_q;
    now_d       = now_q;
    elapsed_d   = elapsed_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    bit_d       = bit_q;
    f_d         = f_q;
    out_frame_d = out_frame_q;
    out_chg_d   = out_chg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    case (state_q)
      rlsa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          chg_d = 1'b0;
          if (func_i) begin
            // settle: clear the accumulator, report the frame unchanged
            ms_d    = '0;
            state_d = rlsa_pkg::ST_DONE;
          end else begin
            delta_d   = delta_i;
            now_d     = now_time_i;
            elapsed_d = elapsed_w;
            state_d   = rlsa_pkg::ST_ACCUM;
          end
        end
      end

      rlsa_pkg::ST_ACCUM: begin
        // add and clamp; a zero bound holds the accumulator at zero
        ms_d  = clamp_w[SW-1:0];
        rem_d = mag_w[MW-1:0];
        neg_d = clamp_w[16];
        quo_d = '0;
        bit_d = 2'd3;
        if (cfg.step_divisor == '0 || !elapsed_q) begin
          state_d = rlsa_pkg::ST_DONE;
        end else begin
          state_d = rlsa_pkg::ST_DIV;
        end
      end

      rlsa_pkg::ST_DIV: begin
        // one restoring quotient bit per cycle, magnitude truncates to zero
        rem_d = rem_next;
        quo_d = quo_next;
        bit_d = bit_q - 2'd1;
        if (bit_q == 2'd0) begin
          if (quo_next == '0) begin
            state_d = rlsa_pkg::ST_DONE;
          end else begin
            ms_d    = neg_q ? -SW'(rem_next) : SW'(rem_next);
            f_d     = neg_q ? (cur_ext - q_ext) : (cur_ext + q_ext);
            state_d = rlsa_pkg::ST_WRAP;
          end
        end
      end

      rlsa_pkg::ST_WRAP: begin
        // move one frame count per cycle toward 0..FRAME_COUNT-1
        if (f_q[UW-1]) begin
          f_d = alu_res;
        end else if (take_w) begin
          f_d = alu_res;
        end else begin
          cur_d   = f_q[FW-1:0];
          last_d  = now_q;
          chg_d   = 1'b1;
          state_d = rlsa_pkg::ST_DONE;
        end
      end

      rlsa_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_frame_d = rlsa_pkg::FRAME_W'(cur_q);
          out_chg_d   = chg_q;
          out_valid_d = 1'b1;
          state_d     = rlsa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rlsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlsa_pkg::ST_IDLE;
      ms_q        <= '0;
      cur_q       <= '0;
      last_q      <= '0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ms_q        <= ms_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      chg_q       <= chg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q     <= delta_d;
    now_q       <= now_d;
    elapsed_q   <= elapsed_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    quo_q       <= quo_d;
    bit_q       <= bit_d;
    f_q         <= f_d;
    out_frame_q <= out_frame_d;
    out_chg_q   <= out_chg_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_index_o   = out_frame_q;
  assign frame_changed_o = out_chg_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_frame_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= FW'(FRAME_COUNT - 1))
    else $error("frame index out of range");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rlsa_pkg::ST_DIV) |-> (rem_q <= limit_w))
    else $error("remainder exceeds clamp bound during division");

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == rlsa_pkg::ST_DONE))
    else $error("result raised outside the final state");

  a_last_time_only_on_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q != $past(last_q)) |-> (chg_q && state_q == rlsa_pkg::ST_DONE))
    else $error("last change time moved without a frame change");

endmodule
